// ----- src/pbtt_pkg.sv -----
package pbtt_pkg;

  // Field widths fixed by the interface
  localparam int OpW      = 2;
  localparam int GroupW   = 3;
  localparam int SlotW    = 3;
  localparam int PrioReqW = 8;
  localparam int ParamW   = 16;
  localparam int KindW    = 3;
  localparam int PrioW    = 4;

  // Configuration registers
  localparam int NumCfg  = 6;
  localparam int CfgIdxW = 3;
  localparam int CapW    = 4;
  localparam logic [CapW-1:0] CapReset [NumCfg] = '{4'd6, 4'd4, 4'd3, 4'd3, 4'd8, 4'd8};

  // Default geometry
  localparam int DefGroups     = 6;
  localparam int DefSlots      = 8;
  localparam int DefPriorities = 10;

  typedef enum logic [OpW-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_RUN   = 2'd3
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KIND_ALLOC = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_RUN   = 3'd2,
    KIND_EMPTY = 3'd3,
    KIND_IMMED = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AL_RD,
    ST_AL_CHK,
    ST_AL_EMIT,
    ST_AL_IMMED,
    ST_AL_FULL,
    ST_AL_POST,
    ST_FR_RD,
    ST_FR_WR,
    ST_CLR,
    ST_RB_INIT,
    ST_RB_RD,
    ST_RB_CHK,
    ST_RB_LINK,
    ST_RB_END,
    ST_RN_HRD,
    ST_RN_HCHK,
    ST_RN_SCHK,
    ST_RN_END
  } state_e;

endpackage

// ----- src/priority_bucket_task_table_unit.sv -----
// Channel | Handshake                 | Payload
// --------+---------------------------+-------------------------------------------------
// in      | in_valid_i / in_stall_o   | opcode, group, slot, priority_req, param,
//         |                           | sort_now, run_now
// out     | out_valid_o / out_stall_i | out_kind, out_slot, out_priority, out_param,
//         |                           | last_flag
// cfg     | cfg_we_i                  | cfg_idx_i, cfg_data_i (capacity of group 0..5)
//
// One input word is worked at a time; in_stall_o is high while the sequencer is out of
// idle, which can outlast the loading of the last result word into the output register.
// An allocate scans occupied slots up to the first free one, a rebuild reads every slot
// below capacity and links each used one, and a run reads each priority bucket head
// and each listed slot; all steps are bound by the single read port of the slot memory
// and of the bucket-head memory, whose reads are registered.
// Reset clears per-entry valid bits at once; no clearing pass is needed.
// A stalled output word holds; the sequencer waits to push while that word is stalled.
module priority_bucket_task_table_unit #(
  parameter int GROUPS     = pbtt_pkg::DefGroups,
  parameter int SLOTS      = pbtt_pkg::DefSlots,
  parameter int PRIORITIES = pbtt_pkg::DefPriorities
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [pbtt_pkg::OpW-1:0]           opcode_i,
  input  logic [pbtt_pkg::GroupW-1:0]        group_i,
  input  logic [pbtt_pkg::SlotW-1:0]         slot_i,
  input  logic signed [pbtt_pkg::PrioReqW-1:0] priority_req_i,
  input  logic signed [pbtt_pkg::ParamW-1:0] param_i,
  input  logic                               sort_now_i,
  input  logic                               run_now_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pbtt_pkg::KindW-1:0]         out_kind_o,
  output logic [pbtt_pkg::SlotW-1:0]         out_slot_o,
  output logic [pbtt_pkg::PrioW-1:0]         out_priority_o,
  output logic signed [pbtt_pkg::ParamW-1:0] out_param_o,
  output logic                               last_flag_o,
  // configuration
  input  logic                               cfg_we_i,
  input  logic [pbtt_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [pbtt_pkg::CapW-1:0]          cfg_data_i
);
  import pbtt_pkg::*;

  localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;       // slot index
  localparam int CW     = $clog2(SLOTS + 1);                     // capacity 0..SLOTS
  localparam int GIW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;     // group index
  localparam int PIW    = $clog2(PRIORITIES);                    // bucket index
  localparam int SDEPTH = GROUPS * SLOTS;
  localparam int HDEPTH = GROUPS * PRIORITIES;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int HAW    = $clog2(HDEPTH);

  // A link is an index with a valid mark; the all-zero word is the empty link.
  typedef struct packed {
    logic          vld;
    logic [SW-1:0] idx;
  } link_t;

  // Slot entry; the all-zero word is the reset value of an entry.
  typedef struct packed {
    logic              used;
    logic [PrioW-1:0]  prio;
    logic [ParamW-1:0] param;
    link_t             link;
  } sword_t;

  state_e state_q, state_d;

  // Captured request
  logic [GroupW-1:0] grp_q;
  logic [SW-1:0]     slot_q;
  logic [PrioW-1:0]  pr_q;
  logic [ParamW-1:0] par_q;
  logic              sort_q;
  logic              runnow_q;
  logic              after_run_q;
  logic [CW-1:0]     cap_q;
  logic [GIW-1:0]    gi;

  // Sequencer counters and scratch
  logic [SW-1:0]  idx_q, idx_d;
  logic [PIW-1:0] pidx_q, pidx_d;
  sword_t         word_q;
  logic           idx_last, p_last;

  // Pending run word, held back until we know whether it is the last one
  logic              pend_v_q, pend_v_d;
  logic              pend_load;
  logic [SW-1:0]     pend_slot_q;
  logic [PrioW-1:0]  pend_prio_q;
  logic [ParamW-1:0] pend_param_q;

  // Output register
  logic              out_valid_q;
  kind_e             out_kind_q;
  logic [SlotW-1:0]  out_slot_q;
  logic [PrioW-1:0]  out_prio_q;
  logic [ParamW-1:0] out_param_q;
  logic              out_last_q;
  logic              out_free;
  logic              push;
  kind_e             push_kind;
  logic [SlotW-1:0]  push_slot;
  logic [PrioW-1:0]  push_prio;
  logic [ParamW-1:0] push_param;
  logic              push_last;

  // Configuration and per-group flags
  logic [CapW-1:0]   cfg_cap_q [NumCfg];
  logic [GROUPS-1:0] dirty_q;
  logic              dirty_set, dirty_clr;

  // Slot memory
  sword_t                         smem [SDEPTH];
  logic [GROUPS-1:0][SLOTS-1:0]   svld_q;
  logic                           s_re, s_we, s_clr;
  logic [SW-1:0]                  s_rs, s_ws;
  logic [SAW-1:0]                 s_raddr, s_waddr;
  sword_t                         s_wdata, s_rdata_q, s_eff;
  logic                           s_rvld_q;

  // Bucket-head memory
  link_t                             hmem [HDEPTH];
  logic [GROUPS-1:0][PRIORITIES-1:0] hvld_q;
  logic                              h_re, h_we, h_clr;
  logic [PIW-1:0]                    h_rp, h_wp;
  logic [HAW-1:0]                    h_raddr, h_waddr;
  link_t                             h_wdata, h_rdata_q, h_eff;
  logic                              h_rvld_q;

  // Acceptance and request decode
  logic           in_acc, grp_ok, slot_ok, dirty_in;
  logic [CW-1:0]  cap_in;
  logic [PrioW-1:0] pr_in;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign grp_ok     = int'(group_i) < GROUPS;
  assign slot_ok    = int'(slot_i) < SLOTS;
  assign dirty_in   = dirty_q[group_i[GIW-1:0]];
  assign gi         = grp_q[GIW-1:0];

  // Capacity above SLOTS counts as SLOTS; groups without a register get all slots.
  always_comb begin
    cap_in = CW'(SLOTS);
    if (int'(group_i) < NumCfg) begin
      if (int'(cfg_cap_q[group_i]) <= SLOTS) begin
        cap_in = CW'(cfg_cap_q[group_i]);
      end
    end
  end

  // Clamp the requested priority into 0..PRIORITIES-1; negative goes to 0.
  always_comb begin
    if (priority_req_i[PrioReqW-1]) begin
      pr_in = '0;
    end else if (int'(priority_req_i) > PRIORITIES - 1) begin
      pr_in = PrioW'(PRIORITIES - 1);
    end else begin
      pr_in = PrioW'(priority_req_i);
    end
  end

  assign idx_last = (CW'(idx_q) + CW'(1)) >= cap_q;
  assign p_last   = (pidx_q == PIW'(PRIORITIES - 1));
  assign out_free = !out_valid_q || !out_stall_i;

  // Entries whose valid bit was clear at read time read as their reset value.
  assign s_eff = s_rvld_q ? s_rdata_q : '0;
  assign h_eff = h_rvld_q ? h_rdata_q : '0;

  assign s_raddr = SAW'(gi) * SAW'(SLOTS) + SAW'(s_rs);
  assign s_waddr = SAW'(gi) * SAW'(SLOTS) + SAW'(s_ws);
  assign h_raddr = HAW'(gi) * HAW'(PRIORITIES) + HAW'(h_rp);
  assign h_waddr = HAW'(gi) * HAW'(PRIORITIES) + HAW'(h_wp);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && grp_ok) begin
          case (opcode_e'(opcode_i))
            OP_ALLOC: state_d = (cap_in == '0) ? ST_AL_FULL : ST_AL_RD;
            OP_FREE:  state_d = slot_ok ? ST_FR_RD : ST_IDLE;
            OP_CLEAR: state_d = ST_CLR;
            OP_RUN:   state_d = dirty_in ? ST_RB_INIT : ST_RN_HRD;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_AL_RD:    state_d = ST_AL_CHK;
      ST_AL_CHK: begin
        if (!s_eff.used) begin
          state_d = ST_AL_EMIT;
        end else if (idx_last) begin
          state_d = ST_AL_FULL;
        end else begin
          state_d = ST_AL_RD;
        end
      end
      ST_AL_EMIT: begin
        if (out_free) begin
          state_d = runnow_q ? ST_AL_IMMED : ST_AL_POST;
        end
      end
      ST_AL_IMMED: if (out_free) state_d = ST_AL_POST;
      ST_AL_FULL:  if (out_free) state_d = ST_AL_POST;
      ST_AL_POST:  state_d = sort_q ? ST_RB_INIT : ST_IDLE;
      ST_FR_RD:    state_d = ST_FR_WR;
      ST_FR_WR:    state_d = ST_IDLE;
      ST_CLR:      state_d = ST_IDLE;
      ST_RB_INIT:  state_d = (cap_q == '0) ? ST_RB_END : ST_RB_RD;
      ST_RB_RD:    state_d = ST_RB_CHK;
      ST_RB_CHK: begin
        if (s_eff.used) begin
          state_d = ST_RB_LINK;
        end else begin
          state_d = idx_last ? ST_RB_END : ST_RB_RD;
        end
      end
      ST_RB_LINK:  state_d = idx_last ? ST_RB_END : ST_RB_RD;
      ST_RB_END:   state_d = after_run_q ? ST_RN_HRD : ST_IDLE;
      ST_RN_HRD:   state_d = ST_RN_HCHK;
      ST_RN_HCHK: begin
        if (h_eff.vld) begin
          state_d = ST_RN_SCHK;
        end else begin
          state_d = p_last ? ST_RN_END : ST_RN_HRD;
        end
      end
      ST_RN_SCHK: begin
        if (!pend_v_q || out_free) begin
          if (s_eff.link.vld) begin
            state_d = ST_RN_SCHK;
          end else begin
            state_d = p_last ? ST_RN_END : ST_RN_HRD;
          end
        end
      end
      ST_RN_END:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer outputs: memory accesses, counters, result words
  // ---------------------------------------------------------------------------
  always_comb begin
    s_re       = 1'b0;
    s_we       = 1'b0;
    s_clr      = 1'b0;
    s_rs       = idx_q;
    s_ws       = idx_q;
    s_wdata    = s_eff;
    h_re       = 1'b0;
    h_we       = 1'b0;
    h_clr      = 1'b0;
    h_rp       = pidx_q;
    h_wp       = PIW'(word_q.prio);
    h_wdata    = '{vld: 1'b1, idx: idx_q};
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    pend_v_d   = pend_v_q;
    pend_load  = 1'b0;
    dirty_set  = 1'b0;
    dirty_clr  = 1'b0;
    push       = 1'b0;
    push_kind  = KIND_RUN;
    push_slot  = SlotW'(pend_slot_q);
    push_prio  = pend_prio_q;
    push_param = pend_param_q;
    push_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          idx_d    = '0;
          pidx_d   = '0;
          pend_v_d = 1'b0;
        end
      end
      ST_AL_RD: s_re = 1'b1;
      ST_AL_CHK: begin
        // Claim the first free slot; keep its stale link as it was.
        if (!s_eff.used) begin
          s_we    = 1'b1;
          s_wdata = '{used: 1'b1, prio: pr_q, param: par_q, link: s_eff.link};
        end else if (!idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_AL_EMIT: begin
        push       = out_free;
        push_kind  = KIND_ALLOC;
        push_slot  = SlotW'(idx_q);
        push_prio  = pr_q;
        push_param = par_q;
        push_last  = !runnow_q;
      end
      ST_AL_IMMED: begin
        push       = out_free;
        push_kind  = KIND_IMMED;
        push_slot  = SlotW'(idx_q);
        push_prio  = pr_q;
        push_param = par_q;
        push_last  = 1'b1;
      end
      ST_AL_FULL: begin
        push       = out_free;
        push_kind  = KIND_FULL;
        push_slot  = '0;
        push_prio  = '0;
        push_param = '0;
        push_last  = 1'b1;
      end
      ST_AL_POST: dirty_set = !sort_q;
      ST_FR_RD: begin
        s_re = 1'b1;
        s_rs = slot_q;
      end
      ST_FR_WR: begin
        // Release the slot but keep its link.
        s_we      = 1'b1;
        s_ws      = slot_q;
        s_wdata   = '{used: 1'b0, prio: '0, param: '0, link: s_eff.link};
        dirty_set = 1'b1;
      end
      ST_CLR: begin
        s_clr = 1'b1;
        h_clr = 1'b1;
      end
      ST_RB_INIT: begin
        h_clr = 1'b1;
        idx_d = '0;
      end
      ST_RB_RD: s_re = 1'b1;
      ST_RB_CHK: begin
        if (s_eff.used) begin
          h_re = 1'b1;
          h_rp = PIW'(s_eff.prio);
        end else if (!idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_RB_LINK: begin
        // Push the slot onto the front of its bucket.
        s_we    = 1'b1;
        s_wdata = '{used: word_q.used, prio: word_q.prio, param: word_q.param,
                    link: h_eff};
        h_we    = 1'b1;
        if (!idx_last) begin
          idx_d = idx_q + SW'(1);
        end
      end
      ST_RB_END: begin
        dirty_clr = 1'b1;
        pidx_d    = '0;
        pend_v_d  = 1'b0;
      end
      ST_RN_HRD: h_re = 1'b1;
      ST_RN_HCHK: begin
        if (h_eff.vld) begin
          s_re  = 1'b1;
          s_rs  = h_eff.idx;
          idx_d = h_eff.idx;
        end else if (!p_last) begin
          pidx_d = pidx_q + PIW'(1);
        end
      end
      ST_RN_SCHK: begin
        if (!pend_v_q || out_free) begin
          push      = pend_v_q;
          pend_v_d  = 1'b1;
          pend_load = 1'b1;
          if (s_eff.link.vld) begin
            s_re  = 1'b1;
            s_rs  = s_eff.link.idx;
            idx_d = s_eff.link.idx;
          end else if (!p_last) begin
            pidx_d = pidx_q + PIW'(1);
          end
        end
      end
      ST_RN_END: begin
        push      = out_free;
        push_last = 1'b1;
        if (!pend_v_q) begin
          push_kind  = KIND_EMPTY;
          push_slot  = '0;
          push_prio  = '0;
          push_param = '0;
        end
        if (out_free) begin
          pend_v_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      dirty_q     <= '0;
      svld_q      <= '0;
      hvld_q      <= '0;
      s_rvld_q    <= 1'b0;
      h_rvld_q    <= 1'b0;
      for (int i = 0; i < NumCfg; i++) begin
        cfg_cap_q[i] <= CapReset[i];
      end
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      pidx_q   <= pidx_d;
      pend_v_q <= pend_v_d;

      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (dirty_set) begin
        dirty_q[gi] <= 1'b1;
      end else if (dirty_clr) begin
        dirty_q[gi] <= 1'b0;
      end

      // Valid bits: drop a whole group at once, mark each entry on write.
      for (int g = 0; g < GROUPS; g++) begin
        if (s_clr && (gi == GIW'(g))) begin
          svld_q[g] <= '0;
        end
        if (h_clr && (gi == GIW'(g))) begin
          hvld_q[g] <= '0;
        end
      end
      if (s_we) begin
        svld_q[gi][s_ws] <= 1'b1;
      end
      if (h_we) begin
        hvld_q[gi][h_wp] <= 1'b1;
      end
      if (s_re) begin
        s_rvld_q <= svld_q[gi][s_rs];
      end
      if (h_re) begin
        h_rvld_q <= hvld_q[gi][h_rp];
      end

      if (cfg_we_i && (int'(cfg_idx_i) < NumCfg)) begin
        cfg_cap_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      grp_q       <= group_i;
      slot_q      <= SW'(slot_i);
      pr_q        <= pr_in;
      par_q       <= param_i;
      sort_q      <= sort_now_i;
      runnow_q    <= run_now_i;
      after_run_q <= (opcode_e'(opcode_i) == OP_RUN);
      cap_q       <= cap_in;
    end
    if (state_q == ST_RB_CHK) begin
      word_q <= s_eff;
    end
    if (pend_load) begin
      pend_slot_q  <= idx_q;
      pend_prio_q  <= s_eff.prio;
      pend_param_q <= s_eff.param;
    end
    if (push) begin
      out_kind_q  <= push_kind;
      out_slot_q  <= push_slot;
      out_prio_q  <= push_prio;
      out_param_q <= push_param;
      out_last_q  <= push_last;
    end
  end

  // Slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      s_rdata_q <= smem[s_raddr];
    end
  end

  // Bucket-head memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hmem[h_waddr] <= h_wdata;
    end
    if (h_re) begin
      h_rdata_q <= hmem[h_raddr];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = out_kind_q;
  assign out_slot_o     = out_slot_q;
  assign out_priority_o = out_prio_q;
  assign out_param_o    = out_param_q;
  assign last_flag_o    = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The sequencer never reads and writes the same slot entry in one cycle.
  a_slot_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_we && s_re) |-> (s_waddr != s_raddr))
    else $error("slot memory read and write hit the same entry");

  // A finished rebuild leaves its group clean.
  a_rebuild_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RB_END) |=> !dirty_q[gi])
    else $error("group still dirty after rebuild");

  // Full and empty markers carry zero fields and close the input's results.
  a_marker_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_kind_o == KIND_EMPTY || out_kind_o == KIND_FULL)) |->
    (out_slot_o == '0 && out_priority_o == '0 && out_param_o == '0 && last_flag_o))
    else $error("marker word with nonzero fields or without last flag");

  // Listed slots always carry a priority inside the bucket range.
  a_run_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_kind_o == KIND_RUN) |-> (int'(out_priority_o) < PRIORITIES))
    else $error("run word priority out of range");

endmodule

// ----- test/tb.sv -----
module tb;
  import pbtt_pkg::*;

  localparam int          CycleLimit  = 400000;
  localparam int          SettleWait  = 64;    // covers a full allocate plus rebuild
  localparam int          PhaseWords  = 46;
  localparam logic [3:0]  NoLink      = 4'hF;  // any link at or above the slot count is empty
  localparam logic [23:0] CapAtReset  = {4'd8, 4'd8, 4'd3, 4'd3, 4'd4, 4'd6};

  typedef struct packed {
    opcode_e                    op;
    logic [GroupW-1:0]          group;
    logic [SlotW-1:0]           slot;
    logic signed [PrioReqW-1:0] prio;
    logic signed [ParamW-1:0]   param;
    logic                       sort_now;
    logic                       run_now;
  } task_word_t;

  typedef struct packed {
    kind_e                    kind;
    logic [SlotW-1:0]         slot;
    logic [PrioW-1:0]         prio;
    logic signed [ParamW-1:0] param;
    logic                     last;
  } result_t;

  // Drive every input to a known value from time zero
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic [OpW-1:0]             opcode_i       = '0;
  logic [GroupW-1:0]          group_i        = '0;
  logic [SlotW-1:0]           slot_i         = '0;
  logic signed [PrioReqW-1:0] priority_req_i = '0;
  logic signed [ParamW-1:0]   param_i        = '0;
  logic                       sort_now_i     = 1'b0;
  logic                       run_now_i      = 1'b0;
  logic                       out_stall_i    = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]         cfg_idx_i      = '0;
  logic [CapW-1:0]            cfg_data_i     = '0;

  logic                       in_stall_o;
  logic                       out_valid_o;
  logic [KindW-1:0]           out_kind_o;
  logic [SlotW-1:0]           out_slot_o;
  logic [PrioW-1:0]           out_priority_o;
  logic signed [ParamW-1:0]   out_param_o;
  logic                       last_flag_o;

  priority_bucket_task_table_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .group_i        (group_i),
    .slot_i         (slot_i),
    .priority_req_i (priority_req_i),
    .param_i        (param_i),
    .sort_now_i     (sort_now_i),
    .run_now_i      (run_now_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_kind_o     (out_kind_o),
    .out_slot_o     (out_slot_o),
    .out_priority_o (out_priority_o),
    .out_param_o    (out_param_o),
    .last_flag_o    (last_flag_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the task table. Updated at the edge where a word is taken,
  // so the queue below always holds the result words the block still owes.
  // ---------------------------------------------------------------------------
  logic [CapW-1:0]          cap_q   [NumCfg];
  bit                       used_q  [DefGroups][DefSlots];
  logic [PrioW-1:0]         prio_q  [DefGroups][DefSlots];
  logic signed [ParamW-1:0] par_q   [DefGroups][DefSlots];
  logic [3:0]               link_q  [DefGroups][DefSlots];
  logic [3:0]               head_q  [DefGroups][DefPriorities];
  bit                       dirty_q [DefGroups];

  result_t owed_results [$];
  result_t staged;
  bit      staged_valid = 1'b0;

  bit      steady = 1'b0;      // both sides run without gaps while set
  int      mismatches = 0;
  int      words_sent = 0;
  int      results_seen = 0;
  int      full_seen = 0;
  int      empty_seen = 0;
  int unsigned cycle_count = 0;

  function automatic void reset_table();
    int g, i;
    for (i = 0; i < NumCfg; i++) cap_q[i] = CapAtReset[4*i +: 4];
    for (g = 0; g < DefGroups; g++) begin
      dirty_q[g] = 1'b0;
      for (i = 0; i < DefSlots; i++) begin
        used_q[g][i] = 1'b0;
        prio_q[g][i] = '0;
        par_q[g][i]  = '0;
        link_q[g][i] = NoLink;
      end
      for (i = 0; i < DefPriorities; i++) head_q[g][i] = NoLink;
    end
  endfunction

  function automatic int usable_slots(int g);
    return (cap_q[g] > DefSlots) ? DefSlots : int'(cap_q[g]);
  endfunction

  // Relink every used slot below capacity; later slots end up at the bucket head
  function automatic void rebuild_buckets(int g);
    int i, c;
    c = usable_slots(g);
    for (i = 0; i < DefPriorities; i++) head_q[g][i] = NoLink;
    for (i = 0; i < c; i++) begin
      if (used_q[g][i]) begin
        link_q[g][i] = head_q[g][prio_q[g][i]];
        head_q[g][prio_q[g][i]] = 4'(i);
      end
    end
    dirty_q[g] = 1'b0;
  endfunction

  // Hold back one result so the final one of a word can carry the last marker
  function automatic void add_result(kind_e kind, int s, logic [PrioW-1:0] pr,
                                     logic signed [ParamW-1:0] pa);
    if (staged_valid) owed_results.push_back(staged);
    staged.kind  = kind;
    staged.slot  = SlotW'(s);
    staged.prio  = pr;
    staged.param = pa;
    staged.last  = 1'b0;
    staged_valid = 1'b1;
  endfunction

  function automatic void close_results();
    if (staged_valid) begin
      staged.last = 1'b1;
      owed_results.push_back(staged);
    end
    staged_valid = 1'b0;
  endfunction

  function automatic void apply_to_table(task_word_t w);
    int g, i, c, n, p, id;
    logic [PrioW-1:0] pr;
    g = w.group;
    if (g >= DefGroups) return;
    case (w.op)
      OP_ALLOC: begin
        c = usable_slots(g);
        if (w.prio[PrioReqW-1])         pr = '0;
        else if (w.prio[6:0] > 7'd9)    pr = PrioW'(DefPriorities - 1);
        else                            pr = w.prio[PrioW-1:0];
        i = 0;
        while (i < c && used_q[g][i]) i++;
        if (i < c) begin
          used_q[g][i] = 1'b1;
          prio_q[g][i] = pr;
          par_q[g][i]  = w.param;
          add_result(KIND_ALLOC, i, pr, w.param);
          if (w.run_now) add_result(KIND_IMMED, i, pr, w.param);
        end else begin
          add_result(KIND_FULL, 0, '0, '0);
        end
        if (w.sort_now) rebuild_buckets(g);
        else            dirty_q[g] = 1'b1;
      end
      OP_FREE: begin
        // links stay as they are; the dirty mark forces a rebuild on the next run
        used_q[g][w.slot] = 1'b0;
        prio_q[g][w.slot] = '0;
        par_q[g][w.slot]  = '0;
        dirty_q[g] = 1'b1;
      end
      OP_CLEAR: begin
        for (i = 0; i < DefSlots; i++) begin
          used_q[g][i] = 1'b0;
          prio_q[g][i] = '0;
          par_q[g][i]  = '0;
          link_q[g][i] = NoLink;
        end
        for (i = 0; i < DefPriorities; i++) head_q[g][i] = NoLink;
      end
      default: begin
        // clean buckets are walked as built, even if the capacity moved since
        if (dirty_q[g]) rebuild_buckets(g);
        n = 0;
        for (p = 0; p < DefPriorities && n < DefSlots; p++) begin
          id = head_q[g][p];
          while (id < DefSlots && n < DefSlots) begin
            add_result(KIND_RUN, id, prio_q[g][id], par_q[g][id]);
            n++;
            id = link_q[g][id];
          end
        end
        if (n == 0) add_result(KIND_EMPTY, 0, '0, '0);
      end
    endcase
    close_results();
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic task_word_t word_of(opcode_e op, int g, int s, int pr, int pa,
                                         bit srt, bit run);
    task_word_t w;
    w.op       = op;
    w.group    = GroupW'(g);
    w.slot     = SlotW'(s);
    w.prio     = PrioReqW'(pr);
    w.param    = ParamW'(pa);
    w.sort_now = srt;
    w.run_now  = run;
    return w;
  endfunction

  function automatic task_word_t random_word(bit noise);
    task_word_t w;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50)      w.op = OP_ALLOC;
    else if (pick < 75) w.op = OP_RUN;
    else if (pick < 93) w.op = OP_FREE;
    else                w.op = OP_CLEAR;
    w.group = noise ? GroupW'($urandom_range(DefGroups, 7))
                    : GroupW'($urandom_range(0, DefGroups - 1));
    w.slot  = SlotW'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      6:       w.prio = {1'b1, 7'($urandom_range(0, 127))};  // negative
      7:       w.prio = PrioReqW'($urandom);
      8:       w.prio = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
      9:       w.prio = PrioReqW'($urandom_range(10, 20));
      default: w.prio = PrioReqW'($urandom_range(0, DefPriorities - 1));
    endcase
    w.param    = ParamW'($urandom);
    w.sort_now = $urandom_range(0, 1);
    w.run_now  = $urandom_range(0, 1);
    return w;
  endfunction

  // Present one word and hold it until the block takes it. Valid stays high
  // on return, so the next word can follow on the very next edge.
  task automatic issue_word(input task_word_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= w.op;
    group_i        <= w.group;
    slot_i         <= w.slot;
    priority_req_i <= w.prio;
    param_i        <= w.param;
    sort_now_i     <= w.sort_now;
    run_now_i      <= w.run_now;
    do @(posedge clk_i); while (in_stall_o);
    apply_to_table(w);
    if (w.group < DefGroups) words_sent++;
  endtask

  // Drop valid, wait for every owed word, then cover words that owe nothing
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // Only call while idle. Also pokes an unused index, which must change nothing.
  task automatic program_capacities(int c0, int c1, int c2, int c3, int c4, int c5);
    logic [CapW-1:0] v [NumCfg];
    int i;
    v[0] = CapW'(c0); v[1] = CapW'(c1); v[2] = CapW'(c2);
    v[3] = CapW'(c3); v[4] = CapW'(c4); v[5] = CapW'(c5);
    for (i = 0; i < NumCfg; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CfgIdxW'(i);
      cfg_data_i <= v[i];
      @(posedge clk_i);
      cap_q[i] = v[i];
    end
    cfg_idx_i  <= CfgIdxW'(7);
    cfg_data_i <= CapW'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_after_reset();
    issue_word(word_of(OP_RUN, 0, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_RUN, 5, 7, -1, -1, 1, 1));
    drain_and_settle();
  endtask

  // Group 2 holds three slots at reset: fill it with clamped priorities
  task automatic test_allocate_clamp();
    issue_word(word_of(OP_ALLOC, 2, 0, 127, 32767, 0, 1));
    issue_word(word_of(OP_ALLOC, 2, 5, -128, -32768, 1, 0));
    issue_word(word_of(OP_ALLOC, 2, 3, 10, 16'h5A5A, 0, 1));
    drain_and_settle();
  endtask

  // A full group still sorts but reports no immediate run
  task automatic test_group_full();
    issue_word(word_of(OP_ALLOC, 2, 0, 5, 1234, 1, 1));
    issue_word(word_of(OP_RUN, 2, 0, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_free_slot();
    issue_word(word_of(OP_FREE, 2, 1, 0, 0, 0, 0));
    issue_word(word_of(OP_FREE, 2, 7, 0, 0, 0, 0));   // above capacity, never used
    issue_word(word_of(OP_RUN, 2, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_ALLOC, 2, 0, -1, -2, 0, 1)); // takes the freed slot back
    drain_and_settle();
  endtask

  task automatic test_clear_group();
    issue_word(word_of(OP_CLEAR, 2, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_RUN, 2, 0, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  // Groups past the last one are dropped without a result
  task automatic test_ignored_groups();
    issue_word(word_of(OP_ALLOC, 6, 0, 3, 77, 1, 1));
    issue_word(word_of(OP_RUN, 7, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_FREE, 7, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_CLEAR, 6, 0, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_capacity_extremes();
    program_capacities(0, 15, 1, 8, 2, 8);
    issue_word(word_of(OP_ALLOC, 0, 0, 4, 11, 0, 1));  // no usable slot
    issue_word(word_of(OP_ALLOC, 1, 0, 2, 22, 1, 0));
    issue_word(word_of(OP_ALLOC, 2, 0, 9, 33, 0, 1));
    drain_and_settle();
  endtask

  // Sort at full capacity, shrink it, and walk the old lists before a rebuild
  task automatic test_stale_order();
    issue_word(word_of(OP_ALLOC, 5, 0, 3, 100, 0, 0));
    issue_word(word_of(OP_ALLOC, 5, 0, 3, 200, 0, 0));
    issue_word(word_of(OP_ALLOC, 5, 0, 7, 300, 0, 1));
    issue_word(word_of(OP_ALLOC, 5, 0, 0, 400, 1, 0));
    drain_and_settle();
    program_capacities(0, 15, 1, 8, 2, 1);
    issue_word(word_of(OP_RUN, 5, 0, 0, 0, 0, 0));
    issue_word(word_of(OP_ALLOC, 5, 0, 1, 500, 0, 0));
    issue_word(word_of(OP_RUN, 5, 0, 0, 0, 0, 0));
    drain_and_settle();
  endtask

  task automatic test_random_traffic();
    int phase, k;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_capacities(6, 4, 3, 3, 8, 8);
        1: program_capacities(8, 8, 8, 8, 8, 8);
        2: program_capacities($urandom_range(1, 8), $urandom_range(1, 8),
                              $urandom_range(1, 8), $urandom_range(1, 8),
                              $urandom_range(1, 8), $urandom_range(1, 8));
        3: program_capacities(15, 1, 0, 8, 15, 1);
        default: program_capacities($urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 15),
                                    $urandom_range(0, 15), $urandom_range(0, 15));
      endcase
      for (k = 0; k < PhaseWords; k++) begin
        steady = (k >= 15 && k < 30);
        if ($urandom_range(0, 19) == 0) issue_word(random_word(1'b1));
        if ($urandom_range(0, 39) == 0) drain_and_settle();
        issue_word(random_word(1'b0));
      end
      steady = 1'b0;
      drain_and_settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, watchdog, result checker, sequence
  // ---------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d result words still owed",
               cycle_count, owed_results.size());
      $display("FAIL priority_bucket_task_table_unit");
      $finish;
    end
  end

  // Stall for a random number of cycles before each result word, then take it
  // and compare it with the oldest owed word.
  initial begin : result_checker
    result_t want;
    result_t got;
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = steady ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got.kind  = kind_e'(out_kind_o);
      got.slot  = out_slot_o;
      got.prio  = out_priority_o;
      got.param = out_param_o;
      got.last  = last_flag_o;
      results_seen++;
      if (got.kind == KIND_FULL)  full_seen++;
      if (got.kind == KIND_EMPTY) empty_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: kind=%0d slot=%0d prio=%0d param=%0d last=%0d",
                   got.kind, got.slot, got.prio, got.param, got.last);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: want kind=%0d slot=%0d prio=%0d param=%0d last=%0d, got kind=%0d slot=%0d prio=%0d param=%0d last=%0d",
                     want.kind, want.slot, want.prio, want.param, want.last,
                     got.kind, got.slot, got.prio, got.param, got.last);
        end
      end
    end
  end

  initial begin
    reset_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_after_reset();
    test_allocate_clamp();
    test_group_full();
    test_free_slot();
    test_clear_group();
    test_ignored_groups();
    test_capacity_extremes();
    test_stale_order();
    test_random_traffic();
    drain_and_settle();
    $display("covered %0d task words across directed cases and five capacity settings",
             words_sent);
    $display("checked %0d result words (%0d group full, %0d empty run), %0d mismatches",
             results_seen, full_seen, empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS priority_bucket_task_table_unit");
    end else begin
      $display("FAIL priority_bucket_task_table_unit");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/pbtt_pkg.sv
src/priority_bucket_task_table_unit.sv
test/tb.sv
